// File: design/assert_macros.svh
// Assertion macros used by the checker file bfe_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bfe assertion failed");

// Clocked assertion that also holds during reset.
`define BFE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bfe assertion failed");

`endif

// File: design/bfe_pkg.sv
// Types and constants of the block floating-point encoder.
// No dependencies.
package bfe_pkg;

  localparam int unsigned NumLanes  = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CountW    = 4;
  localparam int unsigned ExpW      = 8;
  localparam int unsigned FracW     = 7;
  localparam int unsigned MantW     = FracW + 1;
  localparam int unsigned WordW     = MantW + 1;
  localparam int unsigned PackedW   = NumLanes * WordW + ExpW;
  localparam int unsigned LowW      = 64;
  localparam int unsigned HighW     = PackedW - LowW;

  // Lane fields after rounding to the top 16 bits of the float32 pattern.
  typedef struct packed {
    logic             valid;
    logic             sign;
    logic [ExpW-1:0]  exp;
    logic [FracW-1:0] frac;
  } lane_t;

endpackage

// File: design/float32_to_block_float80_encoder.sv
// Top level of the block floating-point encoder: input register stage,
// exponent merge, lane alignment and the output register. Depends on bfe_pkg.
//
// One group of eight float32 patterns is taken per clock cycle; busy_o is
// always low. Each transaction yields one 80-bit word on packed_low_o /
// packed_high_o at the end of the pipeline, shown for a single cycle with
// done_o high. The receiver cannot stall: it must take the word in that
// cycle. The three stages are lane rounding, the exponent max tree across the
// lanes, and per-lane shift and rounding; each ends in a register.
module float32_to_block_float80_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bfe_pkg::ValueW-1:0]    value_0_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_1_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_2_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_3_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_4_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_5_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_6_i,
  input  logic [bfe_pkg::ValueW-1:0]    value_7_i,
  input  logic [bfe_pkg::CountW-1:0]    valid_count_i,
  output logic                          done_o,
  output logic [bfe_pkg::LowW-1:0]      packed_low_o,
  output logic [bfe_pkg::HighW-1:0]     packed_high_o
);
  import bfe_pkg::*;

  logic [ValueW-1:0]          values [NumLanes];
  lane_t [NumLanes-1:0]       lanes_d;
  lane_t [NumLanes-1:0]       s1_lanes_q;
  lane_t [NumLanes-1:0]       s2_lanes_q;
  logic [ExpW-1:0]            shared_d;
  logic [ExpW-1:0]            s2_exp_q;
  logic [WordW-1:0]           words [NumLanes];
  logic [PackedW-1:0]         packed_d;
  logic [PackedW-1:0]         packed_q;
  logic                       s1_vld_q;
  logic                       s2_vld_q;
  logic                       done_q;

  assign values[0] = value_0_i;
  assign values[1] = value_1_i;
  assign values[2] = value_2_i;
  assign values[3] = value_3_i;
  assign values[4] = value_4_i;
  assign values[5] = value_5_i;
  assign values[6] = value_6_i;
  assign values[7] = value_7_i;

  for (genvar g = 0; g < NumLanes; g++) begin : g_round
    bfe_round u_round (
      .value_i      (values[g]),
      .lane_valid_i (valid_count_i > CountW'(g)),
      .lane_o       (lanes_d[g])
    );
  end

  bfe_max u_max (
    .lanes_i      (s1_lanes_q),
    .shared_exp_o (shared_d)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_shift
    bfe_shift u_shift (
      .lane_i       (s2_lanes_q[g]),
      .shared_exp_i (s2_exp_q),
      .word_o       (words[g])
    );
  end

  always_comb begin
    packed_d = '0;
    for (int i = 0; i < NumLanes; i++) begin
      packed_d[WordW*i +: WordW] = words[i];
    end
    packed_d[PackedW-1 -: ExpW] = s2_exp_q;
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    s1_lanes_q <= lanes_d;
    s2_lanes_q <= s1_lanes_q;
    s2_exp_q   <= shared_d;
    packed_q   <= packed_d;
  end

  // transaction valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q;
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign packed_low_o  = packed_q[LowW-1:0];
  assign packed_high_o = packed_q[PackedW-1:LowW];

endmodule

// File: design/bfe_round.sv
// Per-lane front end: rounds a float32 pattern to 16 bits and splits its fields.
// Depends on bfe_pkg.
module bfe_round (
  input  logic [bfe_pkg::ValueW-1:0] value_i,
  input  logic                       lane_valid_i,
  output bfe_pkg::lane_t             lane_o
);
  import bfe_pkg::*;

  logic [15:0] upper;

  // Adding 0x8000 and clearing the low half only touches the top 16 bits.
  assign upper = value_i[31:16] + 16'(value_i[15]);

  assign lane_o.valid = lane_valid_i;
  assign lane_o.sign  = upper[15];
  assign lane_o.exp   = upper[14:7];
  assign lane_o.frac  = upper[6:0];

endmodule

// File: design/bfe_max.sv
// Merge stage: largest exponent over the valid lanes, zero when none is valid.
// Depends on bfe_pkg.
module bfe_max (
  input  bfe_pkg::lane_t [bfe_pkg::NumLanes-1:0] lanes_i,
  output logic [bfe_pkg::ExpW-1:0]               shared_exp_o
);
  import bfe_pkg::*;

  logic [ExpW-1:0] lvl0 [NumLanes];
  logic [ExpW-1:0] lvl1 [NumLanes/2];
  logic [ExpW-1:0] lvl2 [NumLanes/4];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      lvl0[i] = lanes_i[i].valid ? lanes_i[i].exp : '0;
    end
    for (int i = 0; i < NumLanes/2; i++) begin
      lvl1[i] = (lvl0[2*i] > lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
    end
    for (int i = 0; i < NumLanes/4; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    shared_exp_o = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

endmodule

// File: design/bfe_shift.sv
// Per-lane back end: aligns the mantissa to the shared exponent and rounds.
// Depends on bfe_pkg.
module bfe_shift (
  input  bfe_pkg::lane_t              lane_i,
  input  logic [bfe_pkg::ExpW-1:0]    shared_exp_i,
  output logic [bfe_pkg::WordW-1:0]   word_o
);
  import bfe_pkg::*;

  logic [ExpW-1:0]  shift;
  logic [2:0]       sh;
  logic [MantW-1:0] full;
  logic [MantW-1:0] mant;

  assign shift = shared_exp_i - lane_i.exp;
  assign sh    = shift[2:0];
  assign full  = {1'b1, lane_i.frac};

  always_comb begin
    priority if (!lane_i.valid) begin
      mant = '0;
    end else if (shift == '0) begin
      mant = full;
    end else if (shift >= ExpW'(MantW)) begin
      mant = '0;
    end else begin
      // round with the last bit shifted out
      mant = (full >> sh) + MantW'(lane_i.frac[sh - 3'd1]);
    end
  end

  assign word_o = {(mant != '0) & lane_i.sign, mant};

endmodule

// File: design/bfe_checker.sv
// Port-level checks of the block floating-point encoder, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [63:0] packed_low_o,
  input logic [15:0] packed_high_o
);

  `BFE_ASSERT_ALWAYS(a_never_busy, clk_i, !busy_o)
  `BFE_ASSERT(a_result_follows, clk_i, rst_ni, start_i && !busy_o |-> ##3 done_o)
  `BFE_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o, 3))
  `BFE_ASSERT(a_sign0_nonzero, clk_i, rst_ni, done_o && packed_low_o[8] |-> packed_low_o[7:0] != 8'd0)
  `BFE_ASSERT(a_sign7_nonzero, clk_i, rst_ni, done_o && packed_high_o[7] |-> {packed_high_o[6:0], packed_low_o[63]} != 8'd0)

endmodule

bind float32_to_block_float80_encoder bfe_checker u_bfe_checker (.*);

// File: tb/float32_to_block_float80_encoder_test.sv
// Self-checking testbench of float32_to_block_float80_encoder: directed groups and
// random groups with and without sender gaps, each checked against an in-bench encoder model.
// Depends on bfe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module float32_to_block_float80_encoder_test;

  import bfe_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 1700;

  localparam logic [ValueW-1:0] RoundAdd  = 32'h0000_8000;
  localparam logic [ValueW-1:0] KeepMask  = 32'hffff_0000;
  localparam logic [MantW-1:0]  HiddenOne = 8'h80;

  typedef logic [NumLanes-1:0][ValueW-1:0] lane_vals_t;

  typedef struct {
    logic [LowW-1:0]  lo;
    logic [HighW-1:0] hi;
  } group_word_t;

  // Holds the words the encoder owes us, oldest first.
  class group_scoreboard;
    group_word_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function group_word_t encode_group(lane_vals_t vals, logic [CountW-1:0] count);
      logic [PackedW-1:0]              word;
      logic [NumLanes-1:0][ValueW-1:0] rnd;
      int unsigned                     n;
      int unsigned                     shared;
      int unsigned                     e;
      int unsigned                     sh;
      logic [FracW-1:0]                frac;
      logic [MantW-1:0]                full;
      logic [MantW-1:0]                m;
      group_word_t                     res;
      n = (count > NumLanes) ? NumLanes : count;
      shared = 0;
      word = '0;
      for (int i = 0; i < NumLanes; i++) begin
        rnd[i] = (vals[i] + RoundAdd) & KeepMask;
        if (i < n && rnd[i][30:23] > shared) shared = rnd[i][30:23];
      end
      for (int i = 0; i < n; i++) begin
        e = rnd[i][30:23];
        frac = rnd[i][22:16];
        sh = shared - e;
        full = HiddenOne | {1'b0, frac};
        // the last bit shifted out rounds the aligned mantissa
        if (sh == 0) m = full;
        else if (sh >= MantW) m = '0;
        else m = (full >> sh) + MantW'((frac >> (sh - 1)) & 7'h1);
        word[WordW*i +: WordW] = {(m != '0) & rnd[i][31], m};
      end
      word[PackedW-1 -: ExpW] = shared[ExpW-1:0];
      res.lo = word[LowW-1:0];
      res.hi = word[PackedW-1:LowW];
      return res;
    endfunction

    function void note_group(lane_vals_t vals, logic [CountW-1:0] count);
      expected_q.push_back(encode_group(vals, count));
    endfunction

    function void check_word(logic [LowW-1:0] lo, logic [HighW-1:0] hi);
      group_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word lo=%h hi=%h", $time, lo, hi);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (lo !== exp_w.lo) begin
        $display("%0t: packed_low expected %h actual %h", $time, exp_w.lo, lo);
        errors++;
      end
      if (hi !== exp_w.hi) begin
        $display("%0t: packed_high expected %h actual %h", $time, exp_w.hi, hi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  lane_vals_t          lanes = '0;
  logic [CountW-1:0]   valid_count_i = '0;
  logic                done_o;
  logic [LowW-1:0]     packed_low_o;
  logic [HighW-1:0]    packed_high_o;
  int unsigned         cycle_count = 0;
  group_scoreboard     sb;

  float32_to_block_float80_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_0_i     (lanes[0]),
    .value_1_i     (lanes[1]),
    .value_2_i     (lanes[2]),
    .value_3_i     (lanes[3]),
    .value_4_i     (lanes[4]),
    .value_5_i     (lanes[5]),
    .value_6_i     (lanes[6]),
    .value_7_i     (lanes[7]),
    .valid_count_i (valid_count_i),
    .done_o        (done_o),
    .packed_low_o  (packed_low_o),
    .packed_high_o (packed_high_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_word(packed_low_o, packed_high_o);
  end

  function automatic logic [ValueW-1:0] fp(logic s, logic [ExpW-1:0] ex,
                                           logic [FracW-1:0] fr, logic [15:0] low);
    return {s, ex, fr, low};
  endfunction

  // sign, exponent near base, random fraction and rounding bits
  function automatic logic [ValueW-1:0] clustered_value(int unsigned base);
    int unsigned delta;
    logic [ExpW-1:0] ex;
    delta = $urandom_range(0, 10);
    ex = (base > delta) ? ExpW'(base - delta) : '0;
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  function automatic lane_vals_t random_group();
    lane_vals_t vals;
    int unsigned base;
    logic noisy;
    base = $urandom_range(0, 255);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < NumLanes; i++) begin
      if (noisy || $urandom_range(0, 9) == 0) vals[i] = $urandom;
      else vals[i] = clustered_value(base);
    end
    return vals;
  endfunction

  function automatic logic [CountW-1:0] random_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CountW'($urandom_range(9, 15));
    return CountW'($urandom_range(1, 8));
  endfunction

  task automatic send_group(lane_vals_t vals, logic [CountW-1:0] cnt, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
      lanes = random_group();
      valid_count_i = CountW'($urandom);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    lanes = vals;
    valid_count_i = cnt;
    do @(posedge clk_i); while (busy_o);
    sb.note_group(vals, cnt);
  endtask

  // hold off new transactions until every word owed has come back
  task automatic drain_words();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    lane_vals_t vals;
    int unsigned idle_pct;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_group('0, 4'd8, 0);
    send_group({NumLanes{32'hffff_ffff}}, 4'd8, 0);  // wraps to zero
    send_group({NumLanes{32'h7fff_ffff}}, 4'd8, 0);  // carries into the sign
    for (int i = 0; i < NumLanes; i++) vals[i] = fp(i[0], 8'd120, FracW'(i * 17), 16'h7fff);
    send_group(vals, 4'd8, 0);
    // lane i sits i below lane 0: alignment shifts 0 to 7
    for (int i = 0; i < NumLanes; i++) vals[i] = fp(i[0], ExpW'(130 - i), 7'h7f ^ FracW'(i), '0);
    send_group(vals, 4'd8, 0);
    for (int i = 0; i < NumLanes; i++) vals[i] = fp(~i[0], ExpW'(130 - i), 7'h2a, 16'h8000);
    send_group(vals, 4'd8, 0);
    // shifts of eight and more; negative lanes must lose their sign
    vals[0] = fp(1'b0, 8'd200, '0, '0);
    for (int i = 1; i < NumLanes; i++) vals[i] = fp(1'b1, ExpW'(193 - i), 7'h7f, '0);
    send_group(vals, 4'd8, 0);
    for (int i = 0; i < NumLanes; i++) vals[i] = i[0] ? 32'hbfff_c123 : 32'h3fff_8000;
    send_group(vals, 4'd8, 0);
    vals = '0;
    vals[0] = fp(1'b0, 8'hff, '0, '0);
    vals[7] = fp(1'b1, 8'h00, 7'h7f, 16'h7fff);
    send_group(vals, 4'd8, 0);
    send_group(random_group(), 4'd0, 0);
    send_group(random_group(), 4'd9, 0);
    send_group(random_group(), 4'd12, 0);
    send_group(random_group(), 4'd15, 0);
    vals = {NumLanes{32'h7f00_0000}};
    vals[0] = fp(1'b1, 8'd3, 7'h11, '0);
    send_group(vals, 4'd1, 0);
    for (int c = 1; c <= NumLanes; c++) send_group(random_group(), CountW'(c), 0);
    drain_words();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 60 : 0;
      for (int n = 0; n < RandomItems / 3; n++) send_group(random_group(), random_count(), idle_pct);
      drain_words();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: float32_to_block_float80_encoder.f
+incdir+design
design/bfe_pkg.sv
design/bfe_round.sv
design/bfe_max.sv
design/bfe_shift.sv
design/float32_to_block_float80_encoder.sv
design/bfe_checker.sv
tb/float32_to_block_float80_encoder_test.sv
